FILE: sv/cabu_pkg.sv
// ----------------------------------------------------------------------------
// cabu_pkg: shared types and constants of the ADC bank unpacker
// Format codes, parser phases, controller states and the command/status
// structs between controller and datapath.
// ----------------------------------------------------------------------------
package cabu_pkg;

  // bank format codes
  localparam logic [7:0] MODE_CELL    = 8'd1;
  localparam logic [7:0] MODE_PACKED  = 8'd2;
  localparam logic [7:0] MODE_ENTRIES = 8'd3;

  // parser phase within a card block
  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_SKIP    = 3'd1,
    PH_PATTERN = 3'd2,
    PH_PACKED  = 3'd3,
    PH_ENTRIES = 3'd4
  } phase_t;

  // controller states
  typedef enum logic [0:0] {
    CTL_IDLE = 1'b0,
    CTL_RUN  = 1'b1
  } ctl_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;  // capture the input word
    logic step;  // perform one decode step on the held word
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic emit;      // current step produces a result
    logic finish;    // current step closes the word
    logic out_free;  // output register can take a result
  } dp_sts_t;

endpackage

FILE: sv/cabu_ctrl.sv
// ----------------------------------------------------------------------------
// cabu_ctrl: word sequencer
// Takes one word, then steps the datapath until the word is finished,
// holding a step that emits while the output register is full.
// ----------------------------------------------------------------------------
module cabu_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output cabu_pkg::dp_cmd_t cmd,
  input  cabu_pkg::dp_sts_t sts
);
  import cabu_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CTL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    case (state)
      CTL_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = CTL_RUN;
        end
      end
      CTL_RUN: begin
        cmd.step = !sts.emit || sts.out_free;
        if (cmd.step && sts.finish) begin
          state_next = CTL_IDLE;
        end
      end
      default: begin
        state_next = CTL_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/cabu_datapath.sv
// ----------------------------------------------------------------------------
// cabu_datapath: parser state, word decoder and output register
// Holds the current word and the card-block parser state; each step decodes
// at most one channel value from the held word into the output register.
// ----------------------------------------------------------------------------
module cabu_datapath (
  input  logic              clk,
  input  logic              rst,
  input  cabu_pkg::dp_cmd_t cmd,
  output cabu_pkg::dp_sts_t sts,
  input  logic [31:0]       s_tdata,  // word
  input  logic [8:0]        s_tuser,  // bank_start, mode[7:0]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [47:0]       m_tdata,  // card_code, channel, cell_id, adc_value, pad
  output logic [0:0]        m_tuser,  // has_cell_id
  output logic              m_tlast
);
  import cabu_pkg::*;

  // held word and decode position
  logic [31:0] word_q;
  logic [5:0]  off, off_next;
  logic        first, first_next;
  logic [1:0]  half, half_next;

  // parser state
  phase_t      phase, phase_next;
  logic [7:0]  fmt;
  logic [5:0]  skip_left, skip_left_next;
  logic [8:0]  card_q, card_q_next;
  logic [31:0] pattern, pattern_next;
  logic [5:0]  nc, nc_next;
  logic [6:0]  el, el_next;
  logic [7:0]  plb, plb_next;
  logic [3:0]  pbc, pbc_next;

  // step results
  logic        emit, finish;
  logic [8:0]  r_card;
  logic [5:0]  r_chan;
  logic [15:0] r_cell;
  logic [15:0] r_adc;
  logic        r_has;
  logic        r_last;

  // scratch
  logic [31:0] w_sh;
  logic [7:0]  skip_sum;
  logic [6:0]  el_hdr;
  logic [11:0] tail_mask;
  logic [11:0] tail_bits;
  logic [11:0] comb_v;
  logic [5:0]  pbc_calc;
  logic [15:0] entry;

  // phase after the trigger words of a card block
  function automatic phase_t after_skip(input logic [7:0] f, input logic [6:0] e);
    phase_t p;
    if (f == MODE_PACKED) begin
      p = PH_PATTERN;
    end else if (e != 7'd0) begin
      p = PH_ENTRIES;
    end else begin
      p = PH_HEADER;
    end
    return p;
  endfunction

  assign w_sh      = word_q >> off[4:0];
  assign skip_sum  = {1'b0, word_q[6:0]} + 8'd3;
  assign tail_mask = 12'hFFF >> pbc;
  assign tail_bits = (word_q[11:0] & tail_mask) << pbc;
  assign comb_v    = {4'b0, plb} | tail_bits;
  assign pbc_calc  = 6'd32 - off;
  assign entry     = half[0] ? word_q[31:16] : word_q[15:0];

  // decode one step of the held word
  always_comb begin
    phase_next     = phase;
    skip_left_next = skip_left;
    card_q_next    = card_q;
    pattern_next   = pattern;
    nc_next        = nc;
    el_next        = el;
    plb_next       = plb;
    pbc_next       = pbc;
    off_next       = off;
    first_next     = first;
    half_next      = half;
    el_hdr         = 7'd0;
    emit           = 1'b0;
    finish         = 1'b0;
    r_card         = card_q;
    r_chan         = 6'd0;
    r_cell         = 16'd0;
    r_adc          = 16'd0;
    r_has          = 1'b0;
    r_last         = 1'b0;
    if (fmt == MODE_CELL) begin
      // cell id and signed value straight from the word
      emit   = 1'b1;
      finish = 1'b1;
      r_card = 9'd0;
      r_cell = word_q[31:16];
      r_adc  = word_q[15:0];
      r_has  = 1'b1;
      r_last = 1'b1;
    end else if (fmt == MODE_PACKED || fmt == MODE_ENTRIES) begin
      case (phase)
        PH_HEADER: begin
          finish         = 1'b1;
          card_q_next    = word_q[22:14];
          el_hdr         = (fmt == MODE_ENTRIES) ? word_q[13:7] : 7'd0;
          el_next        = el_hdr;
          skip_left_next = skip_sum[7:2];
          if (skip_sum[7:2] != 6'd0) begin
            phase_next = PH_SKIP;
          end else begin
            phase_next = after_skip(fmt, el_hdr);
          end
        end
        PH_SKIP: begin
          finish         = 1'b1;
          skip_left_next = skip_left - 6'd1;
          if (skip_left_next == 6'd0) begin
            phase_next = after_skip(fmt, el);
          end
        end
        PH_PATTERN: begin
          finish       = 1'b1;
          pattern_next = word_q;
          nc_next      = 6'd0;
          plb_next     = 8'd0;
          pbc_next     = 4'd0;
          phase_next   = PH_PACKED;
        end
        PH_PACKED: begin
          first_next = 1'b0;
          if (first) begin
            plb_next = 8'd0;
            pbc_next = 4'd0;
          end
          if (first && pbc != 4'd0 && nc < 6'd32) begin
            // finish a long code begun in the previous word
            emit     = 1'b1;
            r_adc    = {4'b0, comb_v} - 16'd256;
            off_next = 6'd12 - {2'b0, pbc};
          end else if (off < 6'd32 && nc < 6'd32) begin
            if (!pattern[nc[4:0]]) begin
              emit     = 1'b1;
              r_adc    = {12'b0, w_sh[3:0]} - 16'd8;
              off_next = off + 6'd4;
            end else if (off <= 6'd20) begin
              emit     = 1'b1;
              r_adc    = {4'b0, w_sh[11:0]} - 16'd256;
              off_next = off + 6'd12;
            end else begin
              // keep the low part of a straddling long code
              finish   = 1'b1;
              plb_next = w_sh[7:0];
              pbc_next = pbc_calc[3:0];
            end
          end else begin
            finish = 1'b1;
            if (nc >= 6'd32) begin
              phase_next = PH_HEADER;
            end
          end
          if (emit) begin
            r_chan  = nc;
            nc_next = nc + 6'd1;
            r_last  = !(off_next < 6'd32 && nc_next < 6'd32 &&
                        (!pattern[nc_next[4:0]] || off_next <= 6'd20));
          end
        end
        PH_ENTRIES: begin
          if (half != 2'd2 && el != 7'd0) begin
            emit      = 1'b1;
            r_chan    = entry[15:10];
            r_adc     = {6'b0, entry[9:0]};
            el_next   = el - 7'd1;
            half_next = half + 2'd1;
            r_last    = half[0] || (el == 7'd1);
          end else begin
            finish = 1'b1;
            if (el == 7'd0) begin
              phase_next = PH_HEADER;
            end
          end
        end
        default: begin
          finish     = 1'b1;
          phase_next = PH_HEADER;
        end
      endcase
    end else begin
      finish = 1'b1;
    end
  end

  assign sts.emit     = emit;
  assign sts.finish   = finish;
  assign sts.out_free = !m_tvalid || m_tready;

  // on load reset the decode position, clear the parser and take the format at bank start; advance on steps
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      fmt       <= 8'd0;
      skip_left <= 6'd0;
      card_q    <= 9'd0;
      pattern   <= 32'd0;
      nc        <= 6'd0;
      el        <= 7'd0;
      plb       <= 8'd0;
      pbc       <= 4'd0;
      off       <= 6'd0;
      first     <= 1'b0;
      half      <= 2'd0;
    end else if (cmd.load) begin
      if (s_tuser[0]) begin
        phase     <= PH_HEADER;
        fmt       <= s_tuser[8:1];
        skip_left <= 6'd0;
        card_q    <= 9'd0;
        pattern   <= 32'd0;
        nc        <= 6'd0;
        el        <= 7'd0;
        plb       <= 8'd0;
        pbc       <= 4'd0;
      end
      off   <= 6'd0;
      first <= 1'b1;
      half  <= 2'd0;
    end else if (cmd.step) begin
      phase     <= phase_next;
      skip_left <= skip_left_next;
      card_q    <= card_q_next;
      pattern   <= pattern_next;
      nc        <= nc_next;
      el        <= el_next;
      plb       <= plb_next;
      pbc       <= pbc_next;
      off       <= off_next;
      first     <= first_next;
      half      <= half_next;
    end
  end

  // hold the word payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word_q <= s_tdata;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.step && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.step && emit) begin
      m_tdata <= {1'b0, r_adc, r_cell, r_chan, r_card};
      m_tuser <= r_has;
      m_tlast <= r_last;
    end
  end

  // a result is only produced into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.step && emit |-> sts.out_free)
    else $error("decode step emitted into a full output register");

  // an emitting step always shows up at the output
  a_emit_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.step && emit |=> m_tvalid)
    else $error("emitted result not presented");

  // between words the packed stream never sits past the last channel
  a_packed_range: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (phase != PH_PACKED || nc < 6'd32))
    else $error("packed phase held with all channels done");

endmodule

FILE: sv/calorimeter_adc_bank_unpacker_top.sv
// ----------------------------------------------------------------------------
// calorimeter_adc_bank_unpacker_top: readout bank to ADC value stream
// Unpacks bank words in cell, packed-channel and entry-list formats.
// ----------------------------------------------------------------------------
// A word is taken in the idle state; in the run state the datapath then decodes
// at most one result per step into the output register, and a step that emits
// waits while that register is full. The next word is taken after the finishing step.
// The input is taken again while a result still waits in the output register.
// Reset: synchronous; clears the parser, format 0 emits nothing until bank start.
module calorimeter_adc_bank_unpacker_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // word
  input  logic [8:0]  s_tuser,   // bank_start, mode[7:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // card_code, channel, cell_id, adc_value, pad
  output logic [0:0]  m_tuser,   // has_cell_id
  output logic        m_tlast
);
  import cabu_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer
  cabu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // decoder and output register
  cabu_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: tb/calorimeter_adc_bank_unpacker_checker.sv
// ----------------------------------------------------------------------------
// calorimeter_adc_bank_unpacker_checker: result predictor and scoreboard
// Watches both stream channels of the unpacker. Every word taken at the input
// runs through a parser of its own that yields the expected ADC results. Every
// result taken at the output is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module calorimeter_adc_bank_unpacker_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // word
  input  logic [8:0]  s_tuser,   // bank_start, mode[7:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,   // card_code, channel, cell_id, adc_value, pad
  input  logic [0:0]  m_tuser,   // has_cell_id
  input  logic        m_tlast,
  output int          err_count,
  output int          pend_count,
  output int          word_count,
  output int          result_count
);
  import cabu_pkg::*;

  typedef struct packed {
    logic [8:0]  card;
    logic [5:0]  chan;
    logic [15:0] cell_id;
    logic [15:0] adc;
    logic        has;
    logic        last;
  } adc_result_t;

  adc_result_t adc_expected_q[$];

  // parser state
  phase_t      ph;
  logic [7:0]  fmt;
  logic [5:0]  skip_cnt;
  logic [8:0]  card_q;
  logic [31:0] pattern_q;
  logic [5:0]  next_chan;
  logic [6:0]  entries_q;
  logic [7:0]  part_bits;
  logic [3:0]  part_cnt;

  int          errs;
  int          words;
  int          results;
  adc_result_t got;
  adc_result_t want;

  task automatic clear_parser();
    ph        = PH_HEADER;
    fmt       = 8'd0;
    skip_cnt  = 6'd0;
    card_q    = 9'd0;
    pattern_q = 32'd0;
    next_chan = 6'd0;
    entries_q = 7'd0;
    part_bits = 8'd0;
    part_cnt  = 4'd0;
  endtask

  task automatic queue_result(input logic [8:0] card, input logic [5:0] chan,
                              input logic [15:0] cell_id, input logic [15:0] adc,
                              input logic has);
    adc_result_t r;
    r.card    = card;
    r.chan    = chan;
    r.cell_id = cell_id;
    r.adc     = adc;
    r.has     = has;
    r.last    = 1'b0;
    adc_expected_q.push_back(r);
  endtask

  // leave the trigger words: pattern word in packed format, else entries, or the next header when there are none
  task automatic end_of_skip();
    if (fmt == MODE_PACKED) begin
      ph = PH_PATTERN;
    end else begin
      ph = (entries_q != 7'd0) ? PH_ENTRIES : PH_HEADER;
    end
  endtask

  // decode one bank word into its expected results
  task automatic unpack_word(input logic [31:0] w, input logic start,
                             input logic [7:0] md);
    int          sz0;
    int          off;
    int          take;
    logic [31:0] v;
    logic [31:0] mask;
    logic [7:0]  sk;
    logic [15:0] e;
    adc_result_t r;
    sz0 = adc_expected_q.size();
    if (start) begin
      clear_parser();
      fmt = md;
    end
    if (fmt == MODE_CELL) begin
      queue_result(9'd0, 6'd0, w[31:16], w[15:0], 1'b1);
    end else if (fmt == MODE_PACKED || fmt == MODE_ENTRIES) begin
      case (ph)
        PH_HEADER: begin
          card_q    = w[22:14];
          entries_q = (fmt == MODE_ENTRIES) ? w[13:7] : 7'd0;
          sk        = {1'b0, w[6:0]} + 8'd3;
          skip_cnt  = sk[7:2];
          if (skip_cnt != 6'd0) ph = PH_SKIP;
          else end_of_skip();
        end
        PH_SKIP: begin
          skip_cnt = skip_cnt - 6'd1;
          if (skip_cnt == 6'd0) end_of_skip();
        end
        PH_PATTERN: begin
          pattern_q = w;
          next_chan = 6'd0;
          part_bits = 8'd0;
          part_cnt  = 4'd0;
          ph        = PH_PACKED;
        end
        PH_PACKED: begin
          off = 0;
          // finish a long code carried over from the previous word
          if (part_cnt != 4'd0 && next_chan < 6'd32) begin
            take = 12 - part_cnt;
            mask = (32'd1 << take) - 32'd1;
            v    = {24'd0, part_bits} | ((w & mask) << part_cnt);
            queue_result(card_q, next_chan, 16'd0, v[15:0] - 16'd256, 1'b0);
            next_chan = next_chan + 6'd1;
            off = take;
          end
          part_bits = 8'd0;
          part_cnt  = 4'd0;
          while (off < 32 && next_chan < 6'd32) begin
            if (!pattern_q[next_chan]) begin
              v = (w >> off) & 32'hF;
              queue_result(card_q, next_chan, 16'd0, v[15:0] - 16'd8, 1'b0);
              off += 4;
            end else if (off + 12 <= 32) begin
              v = (w >> off) & 32'hFFF;
              queue_result(card_q, next_chan, 16'd0, v[15:0] - 16'd256, 1'b0);
              off += 12;
            end else begin
              // hold the low bits of a long code that straddles the word end
              v         = w >> off;
              part_bits = v[7:0];
              v         = 32 - off;
              part_cnt  = v[3:0];
              break;
            end
            next_chan = next_chan + 6'd1;
          end
          if (next_chan >= 6'd32) ph = PH_HEADER;
        end
        PH_ENTRIES: begin
          for (int h = 0; h < 2 && entries_q != 7'd0; h++) begin
            e = (h == 0) ? w[15:0] : w[31:16];
            queue_result(card_q, e[15:10], 16'd0, {6'd0, e[9:0]}, 1'b0);
            entries_q = entries_q - 7'd1;
          end
          if (entries_q == 7'd0) ph = PH_HEADER;
        end
        default: ph = PH_HEADER;
      endcase
    end
    // mark the final result of this word
    if (adc_expected_q.size() > sz0) begin
      r = adc_expected_q.pop_back();
      r.last = 1'b1;
      adc_expected_q.push_back(r);
    end
  endtask

  function automatic int field_diff(input string name, input logic [31:0] expv,
                                    input logic [31:0] actv);
    if (expv !== actv) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, expv, actv);
      return 1;
    end
    return 0;
  endfunction

  // compare results first, then predict from the word taken at this edge
  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      adc_expected_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        results++;
        got.card    = m_tdata[8:0];
        got.chan    = m_tdata[14:9];
        got.cell_id = m_tdata[30:15];
        got.adc     = m_tdata[46:31];
        got.has     = m_tuser[0];
        got.last    = m_tlast;
        if (adc_expected_q.size() == 0) begin
          $error("unexpected result: tdata 0x%0h tuser %0b tlast %0b",
                 m_tdata, m_tuser, m_tlast);
          errs++;
        end else begin
          want = adc_expected_q.pop_front();
          errs += field_diff("card_code", 32'(want.card), 32'(got.card));
          errs += field_diff("channel", 32'(want.chan), 32'(got.chan));
          errs += field_diff("cell_id", 32'(want.cell_id), 32'(got.cell_id));
          errs += field_diff("adc_value", 32'(want.adc), 32'(got.adc));
          errs += field_diff("has_cell_id", 32'(want.has), 32'(got.has));
          errs += field_diff("last", 32'(want.last), 32'(got.last));
        end
      end
      if (s_tvalid && s_tready) begin
        words++;
        unpack_word(s_tdata, s_tuser[0], s_tuser[8:1]);
      end
    end
    err_count    <= errs;
    pend_count   <= adc_expected_q.size();
    word_count   <= words;
    result_count <= results;
  end

endmodule

FILE: tb/calorimeter_adc_bank_unpacker_top_tb.sv
// ----------------------------------------------------------------------------
// calorimeter_adc_bank_unpacker_top_tb: stimulus and verdict for the unpacker
// Feeds directed and random readout banks in all formats with random idle
// cycles on both sides and one long output stall. The checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module calorimeter_adc_bank_unpacker_top_tb;
  import cabu_pkg::*;

  // formats the block does not decode
  localparam logic [7:0] MODE_NONE   = 8'd0;
  localparam logic [7:0] MODE_UNUSED = 8'd4;
  localparam logic [7:0] MODE_TOP    = 8'hFF;

  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_LIMIT     = 50000;

  typedef struct {
    logic [31:0] word;
    logic        start;
    logic [7:0]  mode;
  } bank_word_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = 32'd0;   // word
  logic [8:0]  s_tuser  = 9'd0;    // bank_start, mode[7:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;            // card_code, channel, cell_id, adc_value, pad
  logic [0:0]  m_tuser;            // has_cell_id
  logic        m_tlast;

  int err_count;
  int pend_count;
  int word_count;
  int result_count;

  bank_word_t bank_words_q[$];
  logic       start_pending = 1'b0;
  logic [7:0] cur_mode      = MODE_NONE;
  int         decoded_words = 0;
  int         banks_cell    = 0;
  int         banks_packed  = 0;
  int         banks_entries = 0;
  int         banks_other   = 0;
  int         tx_gap_max    = 0;
  int         rx_gap_max    = 0;
  int         rx_taken      = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  calorimeter_adc_bank_unpacker_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  calorimeter_adc_bank_unpacker_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .m_tlast      (m_tlast),
    .err_count    (err_count),
    .pend_count   (pend_count),
    .word_count   (word_count),
    .result_count (result_count)
  );

  // queue one word; the first word of a bank carries the start flag and mode
  task automatic add_word(input logic [31:0] w);
    bank_word_t bw;
    logic [7:0] junk_mode;
    junk_mode = 8'($urandom);
    bw.word   = w;
    bw.start  = start_pending;
    bw.mode   = start_pending ? cur_mode : junk_mode;
    if (cur_mode == MODE_CELL || cur_mode == MODE_PACKED || cur_mode == MODE_ENTRIES)
      decoded_words++;
    start_pending = 1'b0;
    bank_words_q.push_back(bw);
  endtask

  task automatic open_bank(input logic [7:0] md);
    start_pending = 1'b1;
    cur_mode      = md;
    if (md == MODE_CELL) banks_cell++;
    else if (md == MODE_PACKED) banks_packed++;
    else if (md == MODE_ENTRIES) banks_entries++;
    else banks_other++;
  endtask

  // one card block: header, trigger words, then pattern and data or entries
  task automatic add_card(input logic [7:0] md);
    logic [31:0] hdr;
    logic [31:0] pat;
    int          trig;
    int          ents;
    int          bits;
    int          nwords;
    trig = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 12);
    ents = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 12);
    hdr  = $urandom;
    hdr[6:0]  = 7'(trig);
    hdr[13:7] = 7'(ents);
    add_word(hdr);
    repeat ((trig + 3) / 4) add_word($urandom);
    if (md == MODE_PACKED) begin
      case ($urandom_range(0, 3))
        0:       pat = 32'h0000_0000;
        1:       pat = 32'hFFFF_FFFF;
        default: pat = $urandom;
      endcase
      add_word(pat);
      bits = 0;
      for (int i = 0; i < 32; i++) bits += pat[i] ? 12 : 4;
      nwords = (bits + 31) / 32;
    end else begin
      nwords = (ents + 1) / 2;
    end
    // now and then cut the block short
    if ($urandom_range(0, 7) == 0) nwords = $urandom_range(0, nwords);
    repeat (nwords) add_word($urandom);
  endtask

  task automatic add_bank();
    int         r;
    logic [7:0] md;
    r = $urandom_range(0, 19);
    if (r < 4) md = MODE_CELL;
    else if (r < 10) md = MODE_PACKED;
    else if (r < 17) md = MODE_ENTRIES;
    else md = 8'($urandom);
    open_bank(md);
    if (md == MODE_PACKED || md == MODE_ENTRIES) begin
      repeat ($urandom_range(1, 3)) add_card(md);
    end else begin
      repeat ($urandom_range(1, 8)) add_word($urandom);
    end
    // stray trailing word
    if ($urandom_range(0, 7) == 0) add_word($urandom);
  endtask

  task automatic build_stimulus();
    // words before any bank start: format zero, nothing comes out
    add_word(32'hFFFF_FFFF);
    add_word(32'h0000_0000);
    // cell format, extremes of id and value
    open_bank(MODE_CELL);
    add_word(32'h0000_0000);
    add_word(32'hFFFF_FFFF);
    add_word(32'h1234_8000);
    add_word(32'hABCD_7FFF);
    // formats that are not decoded
    open_bank(MODE_NONE);
    add_word(32'hFFFF_FFFF);
    open_bank(MODE_UNUSED);
    add_word(32'h0000_0000);
    open_bank(MODE_TOP);
    add_word(32'hFFFF_FFFF);
    // entry list: empty card, then odd count behind two trigger words
    open_bank(MODE_ENTRIES);
    add_word({9'd0, 9'h1FF, 7'd0, 7'd0});
    add_word({9'h1FF, 9'h0AA, 7'd3, 7'd5});
    add_word($urandom);
    add_word($urandom);
    add_word(32'h0000_FFFF);
    add_word(32'hDEAD_8001);
    // truncated card, cleared by the next bank start
    add_word({9'd0, 9'h123, 7'd5, 7'd0});
    add_word(32'h5555_AAAA);
    // packed format with long codes, one straddling a word boundary
    open_bank(MODE_PACKED);
    add_word({9'd0, 9'h155, 7'd0, 7'd0});
    add_word(32'h8000_000E);
    add_word(32'hFFFF_FFFF);
    add_word(32'h0000_0000);
    add_word(32'hFFFF_FFFF);
    add_word(32'h0000_0000);
    add_word(32'h1234_5678);
    // random banks
    decoded_words = 0;
    while (decoded_words < 400) add_bank();
  endtask

  // sender: offer each word after a random gap, hold until taken
  initial begin
    int gap;
    bank_word_t bw;
    build_stimulus();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < bank_words_q.size(); i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       tx_gap_max = 0;
          1:       tx_gap_max = 4;
          default: tx_gap_max = 16;
        endcase
      end
      bw  = bank_words_q[i];
      gap = $urandom_range(0, tx_gap_max);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= bw.word;
      s_tuser  <= {bw.mode, bw.start};
      do @(posedge clk); while (!s_tready);
    end
    s_tvalid <= 1'b0;

    // drain the expected results, then give stragglers time to show
    @(posedge clk);
    gap = 0;
    while (pend_count != 0 && gap < DRAIN_LIMIT) begin
      @(posedge clk);
      gap++;
    end
    if (pend_count != 0) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      repeat (30) @(posedge clk);
      $display("Run covered %0d words and %0d results in %0d cell, %0d packed,",
               word_count, result_count, banks_cell, banks_packed);
      $display("%0d entry-list and %0d undecoded banks, with one %0d-cycle output stall.",
               banks_entries, banks_other, HOLD_OFF_CYCLES);
      if (err_count == 0 && pend_count == 0) begin
        $display("TEST PASSED");
      end else begin
        $display("TEST FAILED");
      end
      $finish;
    end
  end

  // receiver: random stalls per result, one long hold-off to back up the block
  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (rx_taken % 50 == 0) rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
      gap = (rx_taken == 100) ? HOLD_OFF_CYCLES : $urandom_range(0, rx_gap_max);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      rx_taken++;
    end
  end

  // hard stop
  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: calorimeter_adc_bank_unpacker_top.f
sv/cabu_pkg.sv
sv/cabu_ctrl.sv
sv/cabu_datapath.sv
sv/calorimeter_adc_bank_unpacker_top.sv
tb/calorimeter_adc_bank_unpacker_checker.sv
tb/calorimeter_adc_bank_unpacker_top_tb.sv
